@@ hw/rtl/pmind_pkg.sv @@
// Shared constants, command codes and saturating helpers for the image distance block.
package pmind_pkg;

	localparam int DEF_INDEX_BITS      = 20;
	localparam int DEF_COORD_FRAC_BITS = 16;
	localparam int FRACM_BITS          = 30;
	localparam int MAT_ROWS            = 3;
	localparam int SQ_IN_BITS          = 64;
	localparam int SQ_OUT_BITS         = 32;

	typedef enum logic [1:0] {
		CMD_CELL = 2'd0,
		CMD_FRAC = 2'd1,
		CMD_PAIR = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [63:0] sat_uadd64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

@@ hw/rtl/pmind_isqrt.sv @@
// Bit-serial integer square root: each pass of one compare/subtract resolves a result bit, most significant first.
module pmind_isqrt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [pmind_pkg::SQ_IN_BITS-1:0]     value,
	output logic                                 busy,
	output logic [pmind_pkg::SQ_OUT_BITS-1:0]    root
);
	import pmind_pkg::*;

	logic                  busy_q;
	logic [SQ_IN_BITS-1:0] v_q;
	logic [SQ_IN_BITS-1:0] r_q;
	logic [SQ_IN_BITS-1:0] bit_q;
	logic [SQ_IN_BITS-1:0] trial;

	assign trial = r_q + bit_q;
	assign busy  = busy_q;
	assign root  = r_q[SQ_OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SQ_IN_BITS'(1) << (SQ_IN_BITS - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(bit_q)) else $error("sqrt bit not one-hot");
	a_rose_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start)) else $error("sqrt busy without start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && bit_q[0] && !start |=> !busy_q) else $error("sqrt did not finish");

endmodule

@@ hw/rtl/periodic_min_nonself_image_distance_top.sv @@
// Top level: periodic cell minimum non-self image distance over one shared 32x32 multiplier.
// Matrix row loads leave in_ready high and can follow back to back.
// A pair keeps in_ready low from acceptance through 54 products in the FA, TA, FB and IMG
// phases, the 26 non-self images (stepping over the self image) and the UPD compare.
// A frame-ending pair adds the square root, longer while the prior result is held.
// Reset clears control, output valid and the running best; matrices undefined until loaded.
module periodic_min_nonself_image_distance_top #(
	parameter int INDEX_BITS      = pmind_pkg::DEF_INDEX_BITS,
	parameter int COORD_FRAC_BITS = pmind_pkg::DEF_COORD_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              cmd,
	input  logic [1:0]              row,
	input  logic signed [31:0]      ax,
	input  logic signed [31:0]      ay,
	input  logic signed [31:0]      az,
	input  logic signed [31:0]      bx,
	input  logic signed [31:0]      by,
	input  logic signed [31:0]      bz,
	input  logic [INDEX_BITS-1:0]   first_index,
	input  logic [INDEX_BITS-1:0]   second_index,
	input  logic                    last_pair,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [31:0]             min_distance,
	output logic [INDEX_BITS:0]     lower_atom,
	output logic [INDEX_BITS:0]     higher_atom
);
	import pmind_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_FA, S_TA, S_FB, S_IMG, S_DIST, S_UPD, S_SQRT
	} state_t;

	state_t state_q;
	logic [1:0] o_q, n_q, i_q, x_q, y_q, z_q;
	logic [2:0] ph_q;

	logic signed [31:0] cmat_q [3][3];
	logic signed [31:0] fmat_q [3][3];
	logic signed [31:0] a_q [3];
	logic signed [31:0] b_q [3];
	logic signed [63:0] fa_q [3];
	logic signed [63:0] ta_q [3];
	logic signed [63:0] fb_q [3];
	logic signed [63:0] pk0_q [3][3];
	logic signed [63:0] pk1_q [3][3];
	logic signed [63:0] pk2_q [3][3];

	logic signed [63:0] acc_q, t_q;
	logic [31:0] ua_q, dm_q;
	logic [63:0] ub_q, p_q, lo_q, d2_q, ibest_q, best_q;
	logic neg_q, use30_q, big_q, last_q;
	logic [INDEX_BITS-1:0] first_q, second_q, bfirst_q, bsecond_q;
	logic out_valid_q;
	logic [31:0] min_distance_q;
	logic [INDEX_BITS:0] lower_q, higher_q;

	logic in_acc, step_end, img_self, img_last, better, sq_start, sq_busy, out_load;
	logic [1:0] c_row, c_col;
	logic signed [31:0] sa_sel;
	logic signed [63:0] sb_sel, img_off, pval, acc_nx, dd;
	logic [31:0] mul_a, mul_b;
	logic [96:0] psum, pshift, rnd;
	logic [63:0] pmag, dmag, sq, d2n, nbest;
	logic [31:0] sq_root;
	logic [INDEX_BITS:0] n1, n2;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign min_distance = min_distance_q;
	assign lower_atom   = lower_q;
	assign higher_atom  = higher_q;

	// operand select for the product phases
	assign c_row = (state_q == S_TA) ? n_q : o_q;
	assign c_col = (state_q == S_TA) ? o_q : n_q;
	assign img_off = (i_q == 2'd0) ? -(64'sd1 <<< FRACM_BITS) :
			(i_q == 2'd2) ? (64'sd1 <<< FRACM_BITS) : 64'sd0;

	always_comb begin
		sa_sel = cmat_q[c_row][c_col];
		sb_sel = fa_q[n_q];
		case (state_q)
			S_FA: begin
				sa_sel = fmat_q[o_q][n_q];
				sb_sel = {{32{a_q[n_q][31]}}, a_q[n_q]};
			end
			S_FB: begin
				sa_sel = fmat_q[o_q][n_q];
				sb_sel = {{32{b_q[n_q][31]}}, b_q[n_q]};
			end
			S_IMG: begin
				sb_sel = sat_add64(fb_q[o_q], img_off);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mul_a = ua_q;
		mul_b = ub_q[31:0];
		if (state_q == S_DIST) begin
			mul_a = dm_q;
			mul_b = dm_q;
		end else if (ph_q == 3'd2) begin
			mul_b = ub_q[63:32];
		end
	end

	// round, shift and saturate the 96-bit magnitude product
	assign rnd    = use30_q ? (97'd1 << (FRACM_BITS - 1)) : (97'd1 << (COORD_FRAC_BITS - 1));
	assign psum   = {1'b0, p_q, 32'd0} + {33'd0, lo_q} + rnd;
	assign pshift = use30_q ? (psum >> FRACM_BITS) : (psum >> COORD_FRAC_BITS);
	assign pmag   = (|pshift[96:63]) ? {1'b0, {63{1'b1}}} : pshift[63:0];
	assign pval   = neg_q ? -$signed(pmag) : $signed(pmag);
	assign acc_nx = sat_add64(acc_q, pval);

	assign dd   = sat_sub64(t_q, ta_q[n_q]);
	assign dmag = dd[63] ? 64'(-dd) : 64'(dd);
	assign sq   = big_q ? {64{1'b1}} : p_q;
	assign d2n  = sat_uadd64(d2_q, sq);

	assign img_self = (x_q == 2'd1) && (y_q == 2'd1) && (z_q == 2'd1);
	assign img_last = (x_q == 2'd2) && (y_q == 2'd2) && (z_q == 2'd2);
	assign step_end = (ph_q == 3'd3);
	assign better   = ibest_q < best_q;
	assign nbest    = better ? ibest_q : best_q;
	assign sq_start = (state_q == S_UPD) && last_q;
	assign out_load = (state_q == S_SQRT) && !sq_busy && (!out_valid_q || out_ready);

	assign n1 = {1'b0, bfirst_q} + (INDEX_BITS + 1)'(1);
	assign n2 = {1'b0, bsecond_q} + (INDEX_BITS + 1)'(1);

	pmind_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (nbest),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// sequencer, running best and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			o_q         <= '0;
			n_q         <= '0;
			i_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			ph_q        <= '0;
			best_q      <= '1;
			bfirst_q    <= '0;
			bsecond_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && cmd == CMD_PAIR) begin
						state_q <= S_FA;
						o_q     <= '0;
						n_q     <= '0;
						i_q     <= '0;
						ph_q    <= '0;
					end
				end
				S_FA, S_TA, S_FB, S_IMG: begin
					if (!step_end) begin
						ph_q <= ph_q + 3'd1;
					end else begin
						ph_q <= '0;
						if (state_q == S_IMG && i_q != 2'd2) begin
							i_q <= i_q + 2'd1;
						end else begin
							i_q <= '0;
							if (n_q != 2'd2) begin
								n_q <= n_q + 2'd1;
							end else begin
								n_q <= '0;
								if (o_q != 2'd2) begin
									o_q <= o_q + 2'd1;
								end else begin
									o_q <= '0;
									case (state_q)
										S_FA:    state_q <= S_TA;
										S_TA:    state_q <= S_FB;
										S_FB:    state_q <= S_IMG;
										default: begin
											state_q <= S_DIST;
											x_q     <= '0;
											y_q     <= '0;
											z_q     <= '0;
										end
									endcase
								end
							end
						end
					end
				end
				S_DIST: begin
					if (ph_q == 3'd0 && img_self) begin
						ph_q <= '0;
						z_q  <= 2'd2;
					end else if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (n_q != 2'd2) begin
							n_q <= n_q + 2'd1;
						end else begin
							n_q <= '0;
							if (img_last) begin
								state_q <= S_UPD;
							end else if (z_q != 2'd2) begin
								z_q <= z_q + 2'd1;
							end else begin
								z_q <= '0;
								if (y_q != 2'd2) begin
									y_q <= y_q + 2'd1;
								end else begin
									y_q <= '0;
									x_q <= x_q + 2'd1;
								end
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_UPD: begin
					if (better) begin
						best_q    <= ibest_q;
						bfirst_q  <= first_q;
						bsecond_q <= second_q;
					end
					state_q <= last_q ? S_SQRT : S_IDLE;
				end
				S_SQRT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						best_q      <= '1;
						bfirst_q    <= '0;
						bsecond_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath storage
	always_ff @(posedge clk) begin
		p_q <= 64'({32'd0, mul_a} * {32'd0, mul_b});
		if (in_acc) begin
			if (cmd == CMD_CELL && row < 2'(MAT_ROWS)) begin
				cmat_q[row][0] <= ax;
				cmat_q[row][1] <= ay;
				cmat_q[row][2] <= az;
			end
			if (cmd == CMD_FRAC && row < 2'(MAT_ROWS)) begin
				fmat_q[row][0] <= ax;
				fmat_q[row][1] <= ay;
				fmat_q[row][2] <= az;
			end
			a_q[0]   <= ax;
			a_q[1]   <= ay;
			a_q[2]   <= az;
			b_q[0]   <= bx;
			b_q[1]   <= by;
			b_q[2]   <= bz;
			first_q  <= first_index;
			second_q <= second_index;
			last_q   <= last_pair;
			acc_q    <= '0;
			d2_q     <= '0;
			ibest_q  <= '1;
		end
		if (state_q == S_FA || state_q == S_TA || state_q == S_FB || state_q == S_IMG) begin
			case (ph_q)
				3'd0: begin
					ua_q    <= sa_sel[31] ? 32'(-sa_sel) : 32'(sa_sel);
					ub_q    <= sb_sel[63] ? 64'(-sb_sel) : 64'(sb_sel);
					neg_q   <= sa_sel[31] ^ sb_sel[63];
					use30_q <= (state_q == S_TA) || (state_q == S_IMG);
				end
				3'd2: lo_q <= p_q;
				3'd3: begin
					if (state_q == S_IMG) begin
						case (o_q)
							2'd0:    pk0_q[n_q][i_q] <= pval;
							2'd1:    pk1_q[n_q][i_q] <= pval;
							default: pk2_q[n_q][i_q] <= pval;
						endcase
					end else if (n_q == 2'd2) begin
						acc_q <= '0;
						case (state_q)
							S_FA:    fa_q[o_q] <= acc_nx;
							S_TA:    ta_q[o_q] <= acc_nx;
							default: fb_q[o_q] <= acc_nx;
						endcase
					end else begin
						acc_q <= acc_nx;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_DIST) begin
			case (ph_q)
				3'd0: t_q <= sat_add64(pk0_q[n_q][x_q], pk1_q[n_q][y_q]);
				3'd1: t_q <= sat_add64(t_q, pk2_q[n_q][z_q]);
				3'd2: begin
					dm_q  <= dmag[31:0];
					big_q <= |dmag[63:32];
				end
				3'd4: begin
					if (n_q == 2'd2) begin
						d2_q <= '0;
						if (d2n < ibest_q)
							ibest_q <= d2n;
					end else begin
						d2_q <= d2n;
					end
				end
				default: begin
				end
			endcase
		end
		if (out_load) begin
			min_distance_q <= sq_root;
			lower_q        <= (n1 < n2) ? n1 : n2;
			higher_q       <= (n1 < n2) ? n2 : n1;
		end
	end

	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIST && img_self) |-> ph_q == 3'd0) else $error("self image visited");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIST) |-> ph_q <= 3'd3) else $error("phase out of range");
	a_sqrt_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> last_q) else $error("root without frame end");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> lower_q <= higher_q) else $error("atoms out of order");
	a_reset_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> best_q == {64{1'b1}}) else $error("best not cleared");

endmodule

@@ dv/pmind_distance_monitor.sv @@
// Monitor for the image distance block: predicts frame minima and compares each result.
`timescale 1ns / 1ps
module pmind_distance_monitor #(
	parameter int IB = pmind_pkg::DEF_INDEX_BITS,
	parameter int FB = pmind_pkg::DEF_COORD_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [1:0]            row,
	input  logic signed [31:0]    ax,
	input  logic signed [31:0]    ay,
	input  logic signed [31:0]    az,
	input  logic signed [31:0]    bx,
	input  logic signed [31:0]    by,
	input  logic signed [31:0]    bz,
	input  logic [IB-1:0]         first_index,
	input  logic [IB-1:0]         second_index,
	input  logic                  last_pair,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [31:0]           min_distance,
	input  logic [IB:0]           lower_atom,
	input  logic [IB:0]           higher_atom,
	output int                    errors,
	output int                    pending
);
	import pmind_pkg::*;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

	typedef struct {
		logic [31:0] distance;
		logic [IB:0] lo;
		logic [IB:0] hi;
	} frame_min_t;

	frame_min_t              frame_q[$];
	logic signed [63:0]      cell_m[3][3];
	logic signed [63:0]      frac_m[3][3];
	logic [63:0]             run_d2;
	logic [IB-1:0]           run_first;
	logic [IB-1:0]           run_second;

	function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] a);
		return a[63] ? (~a + 64'd1) : a;
	endfunction

	function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic [127:0] p;
		logic [63:0]  r;
		p = {64'd0, mag(a)} * {64'd0, mag(b)} + (128'd1 << (sh - 1));
		p = p >> sh;
		r = (p > {64'd0, S64_MAX}) ? S64_MAX : p[63:0];
		return (a[63] != b[63]) ? -r : r;
	endfunction

	function automatic logic [63:0] square_u(input logic signed [63:0] d);
		logic [63:0] u;
		u = mag(d);
		if (u[63:32] != 0)
			return '1;
		return u * u;
	endfunction

	function automatic logic [63:0] add_u(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [31:0] root_floor(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] c;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			c = r | (32'd1 << i);
			if ({32'd0, c} * {32'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] nearest_image_d2(input logic signed [63:0] pa[3],
			input logic signed [63:0] pb[3]);
		logic signed [63:0] fa[3], fb[3], ca[3], fi[3], cb[3];
		logic [63:0]        best, d2;
		best = '1;
		for (int k = 0; k < 3; k++) begin
			fa[k] = 0;
			fb[k] = 0;
			for (int j = 0; j < 3; j++) begin
				fa[k] = add_s(fa[k], mul_round(frac_m[k][j], pa[j], FB));
				fb[k] = add_s(fb[k], mul_round(frac_m[k][j], pb[j], FB));
			end
		end
		for (int j = 0; j < 3; j++) begin
			ca[j] = 0;
			for (int k = 0; k < 3; k++)
				ca[j] = add_s(ca[j], mul_round(cell_m[k][j], fa[k], FRACM_BITS));
		end
		for (int ix = -1; ix <= 1; ix++)
			for (int iy = -1; iy <= 1; iy++)
				for (int iz = -1; iz <= 1; iz++) begin
					if (ix == 0 && iy == 0 && iz == 0)
						continue;
					fi[0] = add_s(fb[0], 64'(ix) <<< FRACM_BITS);
					fi[1] = add_s(fb[1], 64'(iy) <<< FRACM_BITS);
					fi[2] = add_s(fb[2], 64'(iz) <<< FRACM_BITS);
					d2 = 0;
					for (int j = 0; j < 3; j++) begin
						cb[j] = 0;
						for (int k = 0; k < 3; k++)
							cb[j] = add_s(cb[j], mul_round(cell_m[k][j], fi[k], FRACM_BITS));
						d2 = add_u(d2, square_u(sub_s(cb[j], ca[j])));
					end
					if (d2 < best)
						best = d2;
				end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [63:0] pa[3], pb[3];
		logic [63:0]        d2;
		logic [IB:0]        n1, n2;
		frame_min_t         e;
		if (!arst_n) begin
			run_d2 = '1;
			run_first = 0;
			run_second = 0;
			errors = 0;
			pending = 0;
			frame_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				pa = '{64'(ax), 64'(ay), 64'(az)};
				pb = '{64'(bx), 64'(by), 64'(bz)};
				if ((cmd == CMD_CELL || cmd == CMD_FRAC) && row < MAT_ROWS) begin
					for (int j = 0; j < 3; j++)
						if (cmd == CMD_CELL)
							cell_m[row][j] = pa[j];
						else
							frac_m[row][j] = pa[j];
				end else if (cmd == CMD_PAIR) begin
					d2 = nearest_image_d2(pa, pb);
					if (d2 < run_d2) begin
						run_d2 = d2;
						run_first = first_index;
						run_second = second_index;
					end
					if (last_pair) begin
						n1 = {1'b0, run_first} + 1'b1;
						n2 = {1'b0, run_second} + 1'b1;
						e.distance = root_floor(run_d2);
						e.lo = (n1 < n2) ? n1 : n2;
						e.hi = (n1 < n2) ? n2 : n1;
						frame_q.push_back(e);
						run_d2 = '1;
						run_first = 0;
						run_second = 0;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (frame_q.size() == 0) begin
					$error("unexpected result: min_distance %h lower_atom %0d higher_atom %0d",
						min_distance, lower_atom, higher_atom);
					errors++;
				end else begin
					e = frame_q.pop_front();
					if (min_distance !== e.distance) begin
						$error("min_distance: expected %h, got %h", e.distance, min_distance);
						errors++;
					end
					if (lower_atom !== e.lo) begin
						$error("lower_atom: expected %0d, got %0d", e.lo, lower_atom);
						errors++;
					end
					if (higher_atom !== e.hi) begin
						$error("higher_atom: expected %0d, got %0d", e.hi, higher_atom);
						errors++;
					end
				end
			end
			pending = frame_q.size();
		end
	end
endmodule

@@ dv/periodic_min_nonself_image_distance_top_tb.sv @@
// Testbench top: request stimulus, handshake pacing and verdict for the image distance block.
`timescale 1ns / 1ps
module periodic_min_nonself_image_distance_top_tb;
	import pmind_pkg::*;

	localparam int IB = DEF_INDEX_BITS;
	localparam longint CYCLE_LIMIT = 8_000_000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic [1:0]          cmd = CMD_NOP;
	logic [1:0]          row = 0;
	logic signed [31:0]  ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
	logic [IB-1:0]       first_index = 0, second_index = 0;
	logic                last_pair = 0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [31:0]         min_distance;
	logic [IB:0]         lower_atom, higher_atom;
	logic                in_fire = 0;
	int                  errors, pending;
	int                  pace = 0;
	longint              cycles = 0;

	always #5 clk = ~clk;

	periodic_min_nonself_image_distance_top DUT (.*);

	pmind_distance_monitor mon (.*);

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("periodic_min_nonself_image_distance_top_tb: done, errors");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			case (pace)
				2: out_ready = ($urandom_range(99) >= 55);
				3: out_ready = ($urandom_range(99) >= 6);
				default: out_ready = 1;
			endcase

	task automatic send(input cmd_t c, input logic [1:0] r,
			input logic signed [31:0] a0, a1, a2, b0, b1, b2,
			input logic [IB-1:0] i0, i1, input logic lp);
		int gap;
		gap = 0;
		if (pace == 1 && $urandom_range(99) < 55)
			gap = $urandom_range(4, 1);
		if (pace == 3 && $urandom_range(99) < 6)
			gap = $urandom_range(3, 1);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		cmd = c; row = r;
		ax = a0; ay = a1; az = a2; bx = b0; by = b1; bz = b2;
		first_index = i0; second_index = i1; last_pair = lp;
		in_valid = 1;
		do @(negedge clk); while (!in_fire);
	endtask

	task automatic drain;
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic load_box(input logic signed [31:0] lx, ly, lz);
		logic signed [31:0] l[3];
		logic signed [31:0] c[3], f[3];
		l = '{lx, ly, lz};
		for (int k = 0; k < 3; k++) begin
			c = '{0, 0, 0};
			f = '{0, 0, 0};
			c[k] = l[k];
			f[k] = 32'((64'sd1 <<< 46) / 64'(l[k]));
			send(CMD_CELL, 2'(k), c[0], c[1], c[2], 0, 0, 0, 0, 0, 1'($urandom_range(1)));
			send(CMD_FRAC, 2'(k), f[0], f[1], f[2], 0, 0, 0, 0, 0, 1'($urandom_range(1)));
		end
	endtask

	function automatic logic signed [31:0] coord(input logic signed [31:0] span);
		if ($urandom_range(9) == 0)
			return $urandom;
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	initial begin
		logic signed [31:0] sx;
		int                 sent;
		repeat (4) @(negedge clk);
		arst_n = 1;

		load_box(32'sd10 <<< 16, 32'sd10 <<< 16, 32'sd10 <<< 16);
		send(CMD_PAIR, 0, 0, 0, 0, 32'sd1 <<< 16, 0, 0, 0, '1, 0);
		send(CMD_PAIR, 0, 0, 0, 0, 32'sd1 <<< 16, 0, 0, 5, 7, 0);
		send(CMD_PAIR, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, '1, 3, 1);
		send(CMD_CELL, 2'd3, '1, '1, '1, 0, 0, 0, 0, 0, 1);
		send(CMD_NOP, 2'd3, '1, '1, '1, '1, '1, '1, '1, '1, 1);
		send(CMD_PAIR, 0, 32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF,
			12, '1, 1);
		send(CMD_CELL, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
		send(CMD_FRAC, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0, 0);
		send(CMD_PAIR, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 32'h80000000, 9, 9, 1);
		drain();

		sent = 0;
		while (sent < 1730) begin
			if (sent % 400 == 0)
				pace = (sent / 400) % 4;
			case ($urandom_range(99)) inside
				[0:4]: begin
					if ($urandom_range(3) == 0) begin
						drain();
						for (int k = 0; k < 3; k++) begin
							send(CMD_CELL, 2'(k), $urandom, $urandom, $urandom,
								$urandom, $urandom, $urandom, IB'($urandom),
								IB'($urandom), 0);
							send(CMD_FRAC, 2'(k), $urandom, $urandom, $urandom,
								$urandom, $urandom, $urandom, IB'($urandom),
								IB'($urandom), 0);
						end
					end else begin
						load_box($urandom_range(32'h00640000, 32'h00010000),
							$urandom_range(32'h00640000, 32'h00010000),
							$urandom_range(32'h00640000, 32'h00010000));
					end
					sent += 6;
				end
				[5:8]: begin
					send($urandom_range(1) ? CMD_NOP : cmd_t'($urandom_range(1)), 2'd3,
						$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
						IB'($urandom), IB'($urandom), 1'($urandom_range(1)));
					sent++;
				end
				default: begin
					sx = $urandom_range(32'h01000000, 32'h00010000);
					send(CMD_PAIR, 2'($urandom), coord(sx), coord(sx), coord(sx),
						coord(sx), coord(sx), coord(sx), IB'($urandom), IB'($urandom),
						$urandom_range(7) == 0);
					sent++;
				end
			endcase
		end
		send(CMD_PAIR, 0, 0, 0, 0, 0, 0, 0, 1, 2, 1);
		drain();

		if (errors == 0)
			$display("periodic_min_nonself_image_distance_top_tb: done, clean");
		else
			$display("periodic_min_nonself_image_distance_top_tb: done, errors");
		$finish;
	end
endmodule
